### design/register_rename_reorder_buffer_macros.svh
// Assertion macros for the rename map and reorder buffer block.
`ifndef REGISTER_RENAME_REORDER_BUFFER_MACROS_SVH
`define REGISTER_RENAME_REORDER_BUFFER_MACROS_SVH

// Same-cycle implication.
`define RRROB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RRROB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/rrrob_pkg.sv
// Package: sizes, codes and payload types of the rename map and reorder buffer.
package rrrob_pkg;

   localparam int ROB_DEPTH  = 64;
   localparam int ARCH_REGS  = 67;
   localparam int MAX_RETIRE = 8;

   localparam int PTR_W  = $clog2(ROB_DEPTH);
   localparam int OCC_W  = $clog2(ROB_DEPTH + 1);
   localparam int ARCH_W = $clog2(ARCH_REGS);
   localparam int SWC_W  = $clog2(ARCH_REGS + 1);
   localparam int IDX_W  = $clog2(MAX_RETIRE);
   localparam int CNT_W  = $clog2(MAX_RETIRE + 1);

   localparam int OP_W           = 2;
   localparam int REG_W          = 7;
   localparam int SEQ_W          = 32;
   localparam int TAG_W          = 6;
   localparam int KIND_W         = 3;
   localparam int FREE_W         = 7;
   localparam int ROB_ENTRIES_W  = 7;
   localparam int RETIRE_WIDTH_W = 4;
   localparam int USZ_W          = (OCC_W > ROB_ENTRIES_W) ? OCC_W : ROB_ENTRIES_W;
   localparam int ROBW_W         = 1 + REG_W + SEQ_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 72;

   localparam logic [OP_W-1:0] OP_RENAME   = 2'd0;
   localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
   localparam logic [OP_W-1:0] OP_RETIRE   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_RENAMED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_STALLED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ACK     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RETIRED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROB_ENTRIES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETIRE_WIDTH = 2'd1;

   // Request tdata, lowest field last.
   typedef struct packed {
      logic [1:0]       pad;
      logic [TAG_W-1:0] complete_tag;
      logic [SEQ_W-1:0] instr_seq;
      logic [REG_W-1:0] src2_reg;
      logic             has_src2;
      logic [REG_W-1:0] src1_reg;
      logic             has_src1;
      logic [REG_W-1:0] dest_reg;
      logic             has_dest;
   } req_data_type;

   // Response tdata, lowest field last.
   typedef struct packed {
      logic [4:0]        pad;
      logic [FREE_W-1:0] free_entries;
      logic [REG_W-1:0]  retired_dest_reg;
      logic              retired_has_dest;
      logic [SEQ_W-1:0]  retired_seq;
      logic [TAG_W-1:0]  src2_tag;
      logic              src2_in_rob;
      logic [TAG_W-1:0]  src1_tag;
      logic              src1_in_rob;
      logic [TAG_W-1:0]  dest_tag;
   } rsp_data_type;

   // One queued result, before free count and last are attached.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  dest_tag;
      logic              src1_in_rob;
      logic [TAG_W-1:0]  src1_tag;
      logic              src2_in_rob;
      logic [TAG_W-1:0]  src2_tag;
      logic [SEQ_W-1:0]  retired_seq;
      logic              retired_has_dest;
      logic [REG_W-1:0]  retired_dest_reg;
   } res_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p,
                                                 input logic [OCC_W-1:0] s);
      logic [OCC_W-1:0] p1;
      p1 = OCC_W'(p) + OCC_W'(1);
      return (p1 >= s) ? '0 : PTR_W'(p1);
   endfunction

   function automatic logic reg_ok(input logic [REG_W-1:0] r);
      return 32'(r) < ARCH_REGS;
   endfunction

endpackage

### design/rrrob_ram.sv
// Generic simple dual-port RAM with registered read.
module rrrob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### design/register_rename_reorder_buffer.sv
// Top level: rename map table and circular reorder buffer.
//
//  channel  direction  payload
//  req_     in         tuser = operation; tdata = instruction fields
//  rsp_     out        tuser = result_kind; tdata = result fields; tlast = last
//  csr_     in         csr_index selects rob_entries or retire_width
//
// Rename reads the map RAM twice, through its single read port.
// Retire: each retired entry costs a map RAM read and, after an entry was reallocated
// while still mapped, a sweep over every map entry.
// Reset is synchronous; no clearing pass is needed, valid bits live in flops.
// A new request is taken once the last result is in the output register.
module register_rename_reorder_buffer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // has_dest, dest_reg, has_src1, src1_reg, has_src2, src2_reg, instr_seq, complete_tag
   input  logic [rrrob_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation
   input  logic [rrrob_pkg::OP_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // dest_tag, src1_in_rob, src1_tag, src2_in_rob, src2_tag, retired_seq,
   // retired_has_dest, retired_dest_reg, free_entries
   output logic [rrrob_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // result_kind
   output logic [rrrob_pkg::KIND_W-1:0]      rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rrrob_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rrrob_pkg::CSR_DATA_W-1:0]  csr_data
);

`include "register_rename_reorder_buffer_macros.svh"

   localparam int ROB_DEPTH  = rrrob_pkg::ROB_DEPTH;
   localparam int ARCH_REGS  = rrrob_pkg::ARCH_REGS;
   localparam int MAX_RETIRE = rrrob_pkg::MAX_RETIRE;
   localparam int PTR_W      = rrrob_pkg::PTR_W;
   localparam int OCC_W      = rrrob_pkg::OCC_W;
   localparam int ARCH_W     = rrrob_pkg::ARCH_W;
   localparam int SWC_W      = rrrob_pkg::SWC_W;
   localparam int IDX_W      = rrrob_pkg::IDX_W;
   localparam int CNT_W      = rrrob_pkg::CNT_W;
   localparam int USZ_W      = rrrob_pkg::USZ_W;
   localparam int ROBW_W     = rrrob_pkg::ROBW_W;
   localparam int REG_W      = rrrob_pkg::REG_W;
   localparam int SEQ_W      = rrrob_pkg::SEQ_W;
   localparam int TAG_W      = rrrob_pkg::TAG_W;
   localparam int FREE_W     = rrrob_pkg::FREE_W;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] ST_REN_S1 = 3'd1;
   localparam logic [ST_W-1:0] ST_REN_S2 = 3'd2;
   localparam logic [ST_W-1:0] ST_RET_A  = 3'd3;
   localparam logic [ST_W-1:0] ST_RET_B  = 3'd4;
   localparam logic [ST_W-1:0] ST_RET_C  = 3'd5;
   localparam logic [ST_W-1:0] ST_SWEEP  = 3'd6;
   localparam logic [ST_W-1:0] ST_DRAIN  = 3'd7;

   logic [ST_W-1:0]                         st_ff, st_in;
   logic [rrrob_pkg::ROB_ENTRIES_W-1:0]     rob_entries_ff, rob_entries_in;
   logic [rrrob_pkg::RETIRE_WIDTH_W-1:0]    retire_width_ff, retire_width_in;
   rrrob_pkg::req_data_type                 req_in;
   rrrob_pkg::req_data_type                 item_ff, item_in;
   logic [PTR_W-1:0]                        head_ff, head_in, tail_ff, tail_in;
   logic [OCC_W-1:0]                        occ_ff, occ_in;
   logic [ARCH_REGS-1:0]                    map_valid_ff, map_valid_in;
   logic [ROB_DEPTH-1:0]                    rob_ready_ff, rob_ready_in;
   // mref: some map entry may point at this ROB entry; sweep: more than one may
   logic [ROB_DEPTH-1:0]                    mref_ff, mref_in, sweep_ff, sweep_in;
   logic [CNT_W-1:0]                        cnt_ff, cnt_in, left_ff, left_in;
   logic [IDX_W-1:0]                        rd_ff, rd_in;
   logic [SWC_W-1:0]                        sw_ff, sw_in;
   logic                                    s1r_ff, s1r_in;
   logic [PTR_W-1:0]                        s1t_ff, s1t_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   rrrob_pkg::rsp_data_type                 rsp_data_ff, rsp_data_in;
   logic [rrrob_pkg::KIND_W-1:0]            rsp_kind_ff, rsp_kind_in;
   logic                                    rsp_last_ff, rsp_last_in;

   rrrob_pkg::res_type                      buf_ff [MAX_RETIRE];
   logic                                    buf_we;
   logic [IDX_W-1:0]                        buf_wa;
   rrrob_pkg::res_type                      buf_wd;

   logic                                    map_we, map_re;
   logic [ARCH_W-1:0]                       map_wa, map_ra;
   logic [PTR_W-1:0]                        map_wd, map_q;
   logic                                    rob_we, rob_re;
   logic [PTR_W-1:0]                        rob_wa, rob_ra;
   logic [ROBW_W-1:0]                       rob_wd, rob_q;

   logic [OCC_W-1:0]                        used_sz;
   logic [OCC_W-1:0]                        free_now;
   logic [CNT_W-1:0]                        ret_w;

   assign req_in     = rrrob_pkg::req_data_type'(req_tdata);
   assign req_tready = (st_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      logic [USZ_W-1:0] re;
      re = USZ_W'(rob_entries_ff);
      if (re == '0) begin
         used_sz = OCC_W'(1);
      end else if (re > USZ_W'(ROB_DEPTH)) begin
         used_sz = OCC_W'(ROB_DEPTH);
      end else begin
         used_sz = OCC_W'(re);
      end
   end

   always_comb begin
      if (retire_width_ff == '0) begin
         ret_w = CNT_W'(1);
      end else if (32'(retire_width_ff) > MAX_RETIRE) begin
         ret_w = CNT_W'(MAX_RETIRE);
      end else begin
         ret_w = CNT_W'(retire_width_ff);
      end
   end

   assign free_now = (occ_ff >= used_sz) ? '0 : used_sz - occ_ff;

   rrrob_ram #(.WIDTH(PTR_W), .DEPTH(ARCH_REGS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_en   (map_re),
      .rd_addr (map_ra),
      .rd_data (map_q)
   );

   // ROB entry word: has_dest, dest_reg, instr_seq
   rrrob_ram #(.WIDTH(ROBW_W), .DEPTH(ROB_DEPTH)) u_rob_ram (
      .clock   (clock),
      .wr_en   (rob_we),
      .wr_addr (rob_wa),
      .wr_data (rob_wd),
      .rd_en   (rob_re),
      .rd_addr (rob_ra),
      .rd_data (rob_q)
   );

   always_comb begin
      rrrob_pkg::res_type ent;
      rrrob_pkg::res_type rd_ent;
      logic               dmap;
      logic               s2r;
      logic               ret_commit;
      logic               is_last;
      logic               rhd;
      logic [REG_W-1:0]   rdreg;
      logic [SEQ_W-1:0]   rseq;
      logic [ARCH_W-1:0]  chk_a;

      st_in           = st_ff;
      rob_entries_in  = rob_entries_ff;
      retire_width_in = retire_width_ff;
      item_in         = item_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      occ_in          = occ_ff;
      map_valid_in    = map_valid_ff;
      rob_ready_in    = rob_ready_ff;
      mref_in         = mref_ff;
      sweep_in        = sweep_ff;
      cnt_in          = cnt_ff;
      left_in         = left_ff;
      rd_in           = rd_ff;
      sw_in           = sw_ff;
      s1r_in          = s1r_ff;
      s1t_in          = s1t_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_kind_in     = rsp_kind_ff;
      rsp_last_in     = rsp_last_ff;
      buf_we          = 1'b0;
      buf_wa          = '0;
      map_we          = 1'b0;
      map_wa          = '0;
      map_wd          = '0;
      map_re          = 1'b0;
      map_ra          = '0;
      rob_we          = 1'b0;
      rob_wa          = '0;
      rob_wd          = '0;
      rob_re          = 1'b0;
      rob_ra          = '0;
      ent             = '0;
      rd_ent          = buf_ff[rd_ff];
      dmap            = 1'b0;
      s2r             = 1'b0;
      ret_commit      = 1'b0;
      is_last         = 1'b0;
      chk_a           = '0;
      rhd             = rob_q[ROBW_W-1];
      rdreg           = rob_q[ROBW_W-2 -: REG_W];
      rseq            = rob_q[SEQ_W-1:0];

      if (csr_valid) begin
         case (csr_index)
            rrrob_pkg::CSR_ROB_ENTRIES: begin
               rob_entries_in = rrrob_pkg::ROB_ENTRIES_W'(csr_data);
            end
            rrrob_pkg::CSR_RETIRE_WIDTH: begin
               retire_width_in = rrrob_pkg::RETIRE_WIDTH_W'(csr_data);
            end
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               item_in = req_in;
               unique case (req_tuser)
                  rrrob_pkg::OP_RENAME: begin
                     if (occ_ff >= used_sz) begin
                        ent.kind = rrrob_pkg::KIND_STALLED;
                        buf_we   = 1'b1;
                        cnt_in   = CNT_W'(1);
                        rd_in    = '0;
                        st_in    = ST_DRAIN;
                     end else begin
                        map_re = 1'b1;
                        map_ra = ARCH_W'(req_in.src1_reg);
                        st_in  = ST_REN_S1;
                     end
                  end
                  rrrob_pkg::OP_COMPLETE: begin
                     if (32'(req_in.complete_tag) < 32'(used_sz)) begin
                        rob_ready_in[PTR_W'(req_in.complete_tag)] = 1'b1;
                     end
                     ent.kind = rrrob_pkg::KIND_ACK;
                     buf_we   = 1'b1;
                     cnt_in   = CNT_W'(1);
                     rd_in    = '0;
                     st_in    = ST_DRAIN;
                  end
                  rrrob_pkg::OP_RETIRE: begin
                     cnt_in  = '0;
                     left_in = ret_w;
                     st_in   = ST_RET_A;
                  end
                  default: ;
               endcase
            end
         end
         ST_REN_S1: begin
            s1r_in = item_ff.has_src1 && rrrob_pkg::reg_ok(item_ff.src1_reg) &&
                     map_valid_ff[ARCH_W'(item_ff.src1_reg)];
            s1t_in = map_q;
            map_re = 1'b1;
            map_ra = ARCH_W'(item_ff.src2_reg);
            st_in  = ST_REN_S2;
         end
         ST_REN_S2: begin
            s2r  = item_ff.has_src2 && rrrob_pkg::reg_ok(item_ff.src2_reg) &&
                   map_valid_ff[ARCH_W'(item_ff.src2_reg)];
            dmap = item_ff.has_dest && rrrob_pkg::reg_ok(item_ff.dest_reg);
            rob_we = 1'b1;
            rob_wa = tail_ff;
            rob_wd = {item_ff.has_dest, item_ff.dest_reg, item_ff.instr_seq};
            if (dmap) begin
               map_we = 1'b1;
               map_wa = ARCH_W'(item_ff.dest_reg);
               map_wd = tail_ff;
               map_valid_in[ARCH_W'(item_ff.dest_reg)] = 1'b1;
            end
            rob_ready_in[tail_ff] = 1'b0;
            // reallocated while an older mapping may still point here
            if (mref_ff[tail_ff]) begin
               sweep_in[tail_ff] = 1'b1;
            end
            mref_in[tail_ff] = mref_ff[tail_ff] | dmap;
            tail_in          = rrrob_pkg::ptr_next(tail_ff, used_sz);
            occ_in           = occ_ff + OCC_W'(1);
            ent.kind         = rrrob_pkg::KIND_RENAMED;
            ent.dest_tag     = TAG_W'(tail_ff);
            ent.src1_in_rob  = s1r_ff;
            ent.src1_tag     = s1r_ff ? TAG_W'(s1t_ff) : '0;
            ent.src2_in_rob  = s2r;
            ent.src2_tag     = s2r ? TAG_W'(map_q) : '0;
            buf_we           = 1'b1;
            cnt_in           = CNT_W'(1);
            rd_in            = '0;
            st_in            = ST_DRAIN;
         end
         ST_RET_A: begin
            if (left_ff == '0 || occ_ff == '0 || !rob_ready_ff[head_ff]) begin
               if (cnt_ff == '0) begin
                  ent.kind = rrrob_pkg::KIND_NONE;
                  buf_we   = 1'b1;
                  cnt_in   = CNT_W'(1);
               end
               rd_in = '0;
               st_in = ST_DRAIN;
            end else begin
               rob_re = 1'b1;
               rob_ra = head_ff;
               st_in  = ST_RET_B;
            end
         end
         ST_RET_B: begin
            ent.kind             = rrrob_pkg::KIND_RETIRED;
            ent.retired_seq      = rseq;
            ent.retired_has_dest = rhd;
            ent.retired_dest_reg = rdreg;
            buf_we               = 1'b1;
            buf_wa               = IDX_W'(cnt_ff);
            map_re               = 1'b1;
            map_ra               = ARCH_W'(rdreg);
            st_in                = ST_RET_C;
         end
         ST_RET_C: begin
            if (sweep_ff[head_ff]) begin
               sw_in = '0;
               st_in = ST_SWEEP;
            end else begin
               // only the entry's own destination can still point here
               if (rhd && rrrob_pkg::reg_ok(rdreg) && map_valid_ff[ARCH_W'(rdreg)] &&
                   map_q == head_ff) begin
                  map_valid_in[ARCH_W'(rdreg)] = 1'b0;
               end
               ret_commit = 1'b1;
            end
         end
         ST_SWEEP: begin
            if (32'(sw_ff) < ARCH_REGS) begin
               map_re = 1'b1;
               map_ra = ARCH_W'(sw_ff);
            end
            // check the entry read in the previous cycle
            if (sw_ff != '0) begin
               chk_a = ARCH_W'(sw_ff - SWC_W'(1));
               if (map_valid_ff[chk_a] && map_q == head_ff) begin
                  map_valid_in[chk_a] = 1'b0;
               end
            end
            sw_in = sw_ff + SWC_W'(1);
            if (32'(sw_ff) == ARCH_REGS) begin
               sweep_in[head_ff] = 1'b0;
               ret_commit        = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               is_last                      = (CNT_W'(rd_ff) + CNT_W'(1) == cnt_ff);
               rsp_valid_in                 = 1'b1;
               rsp_kind_in                  = rd_ent.kind;
               rsp_last_in                  = is_last;
               rsp_data_in                  = '0;
               rsp_data_in.dest_tag         = rd_ent.dest_tag;
               rsp_data_in.src1_in_rob      = rd_ent.src1_in_rob;
               rsp_data_in.src1_tag         = rd_ent.src1_tag;
               rsp_data_in.src2_in_rob      = rd_ent.src2_in_rob;
               rsp_data_in.src2_tag         = rd_ent.src2_tag;
               rsp_data_in.retired_seq      = rd_ent.retired_seq;
               rsp_data_in.retired_has_dest = rd_ent.retired_has_dest;
               rsp_data_in.retired_dest_reg = rd_ent.retired_dest_reg;
               rsp_data_in.free_entries     = FREE_W'(free_now);
               rd_in                        = rd_ff + IDX_W'(1);
               if (is_last) begin
                  st_in = ST_IDLE;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase

      if (ret_commit) begin
         rob_ready_in[head_ff] = 1'b0;
         mref_in[head_ff]      = 1'b0;
         head_in               = rrrob_pkg::ptr_next(head_ff, used_sz);
         occ_in                = occ_ff - OCC_W'(1);
         cnt_in                = cnt_ff + CNT_W'(1);
         left_in               = left_ff - CNT_W'(1);
         st_in                 = ST_RET_A;
      end

      buf_wd = ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= ST_IDLE;
         rob_entries_ff  <= rrrob_pkg::ROB_ENTRIES_W'(64);
         retire_width_ff <= rrrob_pkg::RETIRE_WIDTH_W'(4);
         head_ff         <= '0;
         tail_ff         <= '0;
         occ_ff          <= '0;
         map_valid_ff    <= '0;
         rob_ready_ff    <= '0;
         mref_ff         <= '0;
         sweep_ff        <= '0;
         cnt_ff          <= '0;
         left_ff         <= '0;
         rd_ff           <= '0;
         sw_ff           <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         st_ff           <= st_in;
         rob_entries_ff  <= rob_entries_in;
         retire_width_ff <= retire_width_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         occ_ff          <= occ_in;
         map_valid_ff    <= map_valid_in;
         rob_ready_ff    <= rob_ready_in;
         mref_ff         <= mref_in;
         sweep_ff        <= sweep_in;
         cnt_ff          <= cnt_in;
         left_ff         <= left_in;
         rd_ff           <= rd_in;
         sw_ff           <= sw_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      s1r_ff      <= s1r_in;
      s1t_ff      <= s1t_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
      if (buf_we) begin
         buf_ff[buf_wa] <= buf_wd;
      end
   end

   `RRROB_ASSERT_IMPL(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_W'(ROB_DEPTH), "occupancy above depth")
   `RRROB_ASSERT_IMPL(a_retire_ready, clock, reset, st_ff == ST_RET_C, rob_ready_ff[head_ff] && occ_ff != '0, "retiring an entry that is not ready")
   `RRROB_ASSERT_IMPL(a_drain_index, clock, reset, st_ff == ST_DRAIN, CNT_W'(rd_ff) < cnt_ff, "drain index past result count")
   `RRROB_ASSERT_NEXT(a_alloc_count, clock, reset, st_ff == ST_REN_S2, occ_ff == $past(occ_ff) + OCC_W'(1), "allocation did not bump occupancy")

endmodule

### test/rrrob_checker.sv
// Checker: predicts rename, complete and retire results and compares them with the response stream.
`timescale 1ns / 1ps

module rrrob_checker
   import rrrob_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]        req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [KIND_W-1:0]      rsp_tuser,
   input  logic                   rsp_tlast,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     errors,
   output int                     outstanding,
   output logic [TAG_W-1:0]       rob_head,
   output logic [OCC_W-1:0]       rob_count,
   output logic [USZ_W-1:0]       rob_size,
   output logic                   rob_all_written
);

   typedef struct {
      logic [KIND_W-1:0] kind;
      rsp_data_type      data;
      logic              last;
   } rob_result;

   logic [ROB_ENTRIES_W-1:0]  cfg_entries;
   logic [RETIRE_WIDTH_W-1:0] cfg_width;

   logic             map_valid [ARCH_REGS];
   logic [TAG_W-1:0] map_tag   [ARCH_REGS];
   logic             rob_ready [ROB_DEPTH];
   logic [7:0]       rob_dest  [ROB_DEPTH];
   logic [SEQ_W-1:0] rob_seq   [ROB_DEPTH];
   logic             rob_written [ROB_DEPTH];
   logic [TAG_W-1:0] head_idx;
   logic [TAG_W-1:0] tail_idx;
   int               occ;

   rob_result due_results[$];
   int        fails = 0;

   function automatic int used_size();
      int s;
      s = cfg_entries;
      if (s == 0) s = 1;
      if (s > ROB_DEPTH) s = ROB_DEPTH;
      return s;
   endfunction

   function automatic logic [TAG_W-1:0] next_idx(input logic [TAG_W-1:0] p);
      return (int'(p) + 1 >= used_size()) ? '0 : p + 1'b1;
   endfunction

   function automatic int free_slots();
      return (occ >= used_size()) ? 0 : used_size() - occ;
   endfunction

   function automatic rob_result blank(input logic [KIND_W-1:0] k);
      rob_result r;
      r.kind = k;
      r.data = '0;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic void lookup_src(input logic has, input logic [REG_W-1:0] r,
                                      output logic hit, output logic [TAG_W-1:0] tag);
      hit = 1'b0;
      tag = '0;
      if (has && r < ARCH_REGS && map_valid[r]) begin
         hit = 1'b1;
         tag = map_tag[r];
      end
   endfunction

   function automatic string show(input logic [KIND_W-1:0] k, input rsp_data_type r,
                                  input logic l);
      return $sformatf("kind %0d dtag %0d src1 %0b/%0d src2 %0b/%0d seq %h dest %0b/%0d free %0d last %0b pad %0h",
                       k, r.dest_tag, r.src1_in_rob, r.src1_tag, r.src2_in_rob, r.src2_tag,
                       r.retired_seq, r.retired_has_dest, r.retired_dest_reg, r.free_entries,
                       l, r.pad);
   endfunction

   task automatic predict_step(input logic [OP_W-1:0] op, input req_data_type d);
      rob_result        res [MAX_RETIRE];
      int               n;
      int               w;
      logic [TAG_W-1:0] h;
      logic             hit1, hit2;
      logic [TAG_W-1:0] tag1, tag2;
      n = 0;
      case (op)
         OP_RENAME: begin
            if (occ >= used_size()) begin
               res[0] = blank(KIND_STALLED);
            end else begin
               // sources see the mapping from before this destination is mapped
               lookup_src(d.has_src1, d.src1_reg, hit1, tag1);
               lookup_src(d.has_src2, d.src2_reg, hit2, tag2);
               res[0] = blank(KIND_RENAMED);
               res[0].data.dest_tag = tail_idx;
               res[0].data.src1_in_rob = hit1;
               res[0].data.src1_tag = tag1;
               res[0].data.src2_in_rob = hit2;
               res[0].data.src2_tag = tag2;
               rob_ready[tail_idx] = 1'b0;
               rob_dest[tail_idx] = {d.has_dest, d.dest_reg};
               rob_seq[tail_idx] = d.instr_seq;
               rob_written[tail_idx] = 1'b1;
               if (d.has_dest && d.dest_reg < ARCH_REGS) begin
                  map_valid[d.dest_reg] = 1'b1;
                  map_tag[d.dest_reg] = tail_idx;
               end
               tail_idx = next_idx(tail_idx);
               occ++;
            end
            n = 1;
         end
         OP_COMPLETE: begin
            if (d.complete_tag < used_size()) rob_ready[d.complete_tag] = 1'b1;
            res[0] = blank(KIND_ACK);
            n = 1;
         end
         OP_RETIRE: begin
            w = cfg_width;
            if (w == 0) w = 1;
            if (w > MAX_RETIRE) w = MAX_RETIRE;
            for (int i = 0; i < w; i++) begin
               h = head_idx;
               if (occ == 0 || !rob_ready[h]) break;
               for (int a = 0; a < ARCH_REGS; a++) begin
                  if (map_valid[a] && map_tag[a] == h) begin
                     map_valid[a] = 1'b0;
                     map_tag[a] = '0;
                  end
               end
               res[n] = blank(KIND_RETIRED);
               res[n].data.retired_seq = rob_seq[h];
               res[n].data.retired_has_dest = rob_dest[h][7];
               res[n].data.retired_dest_reg = rob_dest[h][6:0];
               n++;
               rob_ready[h] = 1'b0;
               head_idx = next_idx(h);
               occ--;
            end
            if (n == 0) begin
               res[0] = blank(KIND_NONE);
               n = 1;
            end
         end
         default: n = 0;
      endcase
      for (int k = 0; k < n; k++) begin
         res[k].data.free_entries = FREE_W'(free_slots());
         res[k].last = (k == n - 1);
         due_results.push_back(res[k]);
      end
   endtask

   task automatic check_result();
      rsp_data_type act;
      rob_result    want;
      logic         bad;
      act = rsp_tdata;
      if (due_results.size() == 0) begin
         fails++;
         if (fails <= 10) $display("%0t: result with none due: %s", $time,
                                   show(rsp_tuser, act, rsp_tlast));
      end else begin
         want = due_results.pop_front();
         bad = (rsp_tuser !== want.kind) || (rsp_tlast !== want.last) ||
               (act.pad !== want.data.pad) ||
               (act.dest_tag !== want.data.dest_tag) ||
               (act.src1_in_rob !== want.data.src1_in_rob) ||
               (act.src1_tag !== want.data.src1_tag) ||
               (act.src2_in_rob !== want.data.src2_in_rob) ||
               (act.src2_tag !== want.data.src2_tag) ||
               (act.retired_seq !== want.data.retired_seq) ||
               (act.retired_has_dest !== want.data.retired_has_dest) ||
               (act.retired_dest_reg !== want.data.retired_dest_reg) ||
               (act.free_entries !== want.data.free_entries);
         if (bad) begin
            fails++;
            if (fails <= 10) begin
               $display("%0t: result mismatch", $time);
               $display("  expected %s", show(want.kind, want.data, want.last));
               $display("  actual   %s", show(rsp_tuser, act, rsp_tlast));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_entries = ROB_ENTRIES_W'(ROB_DEPTH);
         cfg_width = RETIRE_WIDTH_W'(4);
         for (int a = 0; a < ARCH_REGS; a++) begin
            map_valid[a] = 1'b0;
            map_tag[a] = '0;
         end
         for (int e = 0; e < ROB_DEPTH; e++) begin
            rob_ready[e] = 1'b0;
            rob_written[e] = 1'b0;
         end
         head_idx = '0;
         tail_idx = '0;
         occ = 0;
         due_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROB_ENTRIES) cfg_entries = csr_data;
            else if (csr_index == CSR_RETIRE_WIDTH) cfg_width = csr_data[RETIRE_WIDTH_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) predict_step(req_tuser, req_tdata);
      end
      errors <= fails;
      outstanding <= due_results.size();
      rob_head <= head_idx;
      rob_count <= OCC_W'(occ);
      rob_size <= USZ_W'(used_size());
      rob_all_written <= rob_written.and();
   end

endmodule

### test/tb_register_rename_reorder_buffer.sv
// Testbench top: clock, reset, request and register stimulus, and the final verdict.
`timescale 1ns / 1ps

module tb_register_rename_reorder_buffer;
   import rrrob_pkg::*;

   localparam logic [OP_W-1:0]        OP_SPARE  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 50;
   localparam int TAIL_CYCLES   = 700;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]        req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int               errors;
   int               outstanding;
   logic [TAG_W-1:0] rob_head;
   logic [OCC_W-1:0] rob_count;
   logic [USZ_W-1:0] rob_size;
   logic             rob_all_written;

   int burst_left = 0;

   register_rename_reorder_buffer i_dut (.*);

   rrrob_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_register_rename_reorder_buffer: FAIL");
      $finish;
   end

   // receiver: modes of always ready, random stalls and a fixed one-in-four pattern
   initial begin : rsp_backpressure
      int mode;
      int mode_left;
      int cyc;
      mode = 0;
      mode_left = 0;
      cyc = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         cyc++;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 2) != 0);
            2: rsp_tready <= (cyc % 4 == 0);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   function automatic logic [REG_W-1:0] pick_reg();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return REG_W'($urandom_range(0, 7));
      if (r < 97) return REG_W'($urandom_range(0, ARCH_REGS - 1));
      return REG_W'($urandom_range(ARCH_REGS, 127));
   endfunction

   // mostly an in-flight entry near the head, so retires make progress
   function automatic logic [TAG_W-1:0] pick_complete_tag();
      int k;
      int t;
      if (rob_count == 0 || $urandom_range(0, 3) == 0) return TAG_W'($urandom);
      t = rob_head;
      k = $urandom_range(0, (rob_count > 6) ? 5 : rob_count - 1);
      repeat (k) t = (t + 1 >= rob_size) ? 0 : t + 1;
      return TAG_W'(t);
   endfunction

   function automatic req_data_type random_fields();
      req_data_type d;
      d.pad = '0;
      d.has_dest = ($urandom_range(0, 9) != 0);
      d.dest_reg = pick_reg();
      d.has_src1 = ($urandom_range(0, 4) != 0);
      d.src1_reg = pick_reg();
      d.has_src2 = ($urandom_range(0, 2) != 0);
      d.src2_reg = pick_reg();
      d.instr_seq = $urandom;
      d.complete_tag = pick_complete_tag();
      return d;
   endfunction

   function automatic req_data_type instr(input logic hd, input int dr, input logic h1,
                                          input int r1, input logic h2, input int r2,
                                          input logic [SEQ_W-1:0] seq, input int ctag);
      req_data_type d;
      d.pad = '0;
      d.has_dest = hd;
      d.dest_reg = REG_W'(dr);
      d.has_src1 = h1;
      d.src1_reg = REG_W'(r1);
      d.has_src2 = h2;
      d.src2_reg = REG_W'(r2);
      d.instr_seq = seq;
      d.complete_tag = TAG_W'(ctag);
      return d;
   endfunction

   // bursts of transfers separated by random gaps
   task automatic send_item(input logic [OP_W-1:0] op, input req_data_type d);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      wait_drained();
      // a spare opcode leaves no result to wait for
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      send_item(OP_RETIRE, instr(0, 0, 0, 0, 0, 0, 32'h0, 0));            // empty ROB
      send_item(OP_COMPLETE, instr(0, 0, 0, 0, 0, 0, 32'h0, 0));
      send_item(OP_RENAME, instr(1, 0, 0, 0, 0, 0, 32'h0000_0000, 0));
      send_item(OP_RENAME, instr(1, 66, 1, 0, 1, 66, 32'hFFFF_FFFF, 63)); // src2 == dest
      send_item(OP_RENAME, instr(1, 5, 1, 5, 1, 66, 32'h8000_0001, 0));
      send_item(OP_RENAME, instr(1, 5, 1, 5, 0, 66, 32'h5A5A_A5A5, 42));  // older mapping of r5
      send_item(OP_RENAME, instr(1, 127, 1, 67, 1, 127, 32'h1234_5678, 0)); // beyond map
      send_item(OP_RENAME, instr(0, 66, 0, 66, 0, 66, 32'h0F0F_F0F0, 21));
      send_item(OP_RETIRE, instr(0, 0, 0, 0, 0, 0, 32'h0, 0));            // head not ready
      send_item(OP_SPARE, instr(1, 66, 1, 66, 1, 66, 32'hFFFF_FFFF, 63));
      send_item(OP_COMPLETE, instr(0, 0, 0, 0, 0, 0, 32'h0, 1));
      send_item(OP_COMPLETE, instr(0, 0, 0, 0, 0, 0, 32'h0, 0));
      send_item(OP_COMPLETE, instr(0, 0, 0, 0, 0, 0, 32'h0, 3));
      send_item(OP_COMPLETE, instr(0, 0, 0, 0, 0, 0, 32'h0, 2));
      send_item(OP_RETIRE, instr(0, 0, 0, 0, 0, 0, 32'h0, 0));            // full width
      send_item(OP_RENAME, instr(1, 63, 1, 0, 1, 5, 32'hDEAD_BEEF, 0));
      send_item(OP_COMPLETE, instr(0, 0, 0, 0, 0, 0, 32'h0, 5));
      send_item(OP_COMPLETE, instr(0, 0, 0, 0, 0, 0, 32'h0, 4));
      send_item(OP_RETIRE, instr(0, 0, 0, 0, 0, 0, 32'h0, 0));            // stops at head
      send_item(OP_COMPLETE, instr(0, 0, 0, 0, 0, 0, 32'h0, 63));
      send_item(OP_RENAME, instr(1, 1, 1, 63, 1, 63, 32'h0000_0001, 0));
   endtask

   // rename until full so every entry has been written before any resize
   task automatic fill_rob();
      while (!(rob_all_written && rob_count >= rob_size)) send_item(OP_RENAME, random_fields());
      repeat (2) send_item(OP_RENAME, random_fields());
   endtask

   task automatic run_random(input int n);
      int               done;
      int               r;
      logic [OP_W-1:0]  op;
      done = 0;
      while (done < n) begin
         r = $urandom_range(0, 99);
         if (r < 35) op = OP_RENAME;
         else if (r < 70) op = OP_COMPLETE;
         else if (r < 95) op = OP_RETIRE;
         else op = OP_SPARE;
         send_item(op, random_fields());
         if (op != OP_SPARE) done++;
         if ($urandom_range(0, 29) == 0) wait_drained();
      end
   endtask

   initial begin
      int spins;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      fill_rob();

      // shrink while occupied
      write_csr(CSR_ROB_ENTRIES, 7'd5);
      write_csr(CSR_RETIRE_WIDTH, 7'd8);
      run_random(12);

      write_csr(CSR_ROB_ENTRIES, 7'd127);
      write_csr(CSR_RETIRE_WIDTH, 7'd15);
      run_random(35);

      write_csr(CSR_ROB_ENTRIES, 7'd17);
      write_csr(CSR_RETIRE_WIDTH, 7'd3);
      write_csr(CSR_SPARE, 7'($urandom));
      run_random(30);

      write_csr(CSR_ROB_ENTRIES, 7'd0);
      write_csr(CSR_RETIRE_WIDTH, 7'd0);
      run_random(15);

      write_csr(CSR_ROB_ENTRIES, 7'd2);
      write_csr(CSR_RETIRE_WIDTH, 7'd8);
      run_random(15);

      write_csr(CSR_ROB_ENTRIES, 7'd64);
      write_csr(CSR_RETIRE_WIDTH, 7'd1);
      run_random(25);

      req_tvalid <= 1'b0;
      @(posedge clock);
      spins = 0;
      while (outstanding != 0 && spins < 20000) begin
         @(posedge clock);
         spins++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (errors == 0 && outstanding == 0) begin
         $display("tb_register_rename_reorder_buffer: PASS");
      end else begin
         $display("tb_register_rename_reorder_buffer: FAIL");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/rrrob_pkg.sv
design/rrrob_ram.sv
design/register_rename_reorder_buffer.sv
test/rrrob_checker.sv
test/tb_register_rename_reorder_buffer.sv
